// ----- src/bounded_ordered_list_engine_top_assert.svh -----
// ---------------------------------------------------------------------------
// bounded ordered list engine assertion macros
// concurrent assertion helpers, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_LIST_ENGINE_TOP_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTH

`define BOLE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define BOLE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define BOLE_ASSERT(lbl, clk, rstn, prop, msg)

`define BOLE_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ----- src/bole_pkg.sv -----
// ---------------------------------------------------------------------------
// bole_pkg
// shared types, request and status codes for the bounded ordered list engine
// ---------------------------------------------------------------------------
`default_nettype none

package bole_pkg;

  localparam int BOLE_DEPTH = 16;
  localparam int RESULT_CAP = 16;
  localparam int VAL_W      = 32;

  localparam logic [2:0] REQ_INSERT  = 3'd0;
  localparam logic [2:0] REQ_DEL_POS = 3'd1;
  localparam logic [2:0] REQ_DEL_KEY = 3'd2;
  localparam logic [2:0] REQ_REVERSE = 3'd3;
  localparam logic [2:0] REQ_DUMP    = 3'd4;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_BADPOS = 3'd2;
  localparam logic [2:0] ST_NOKEY  = 3'd3;
  localparam logic [2:0] ST_EMPTY  = 3'd4;

  typedef struct packed {
    logic [2:0]              req_type;
    logic signed [VAL_W-1:0] new_value;
    logic [4:0]              position;
    logic signed [VAL_W-1:0] search_key;
  } bole_req_t;

  typedef struct packed {
    logic [2:0]              status;
    logic signed [VAL_W-1:0] out_value;
    logic [4:0]              element_count;
    logic                    last_flag;
  } bole_rsp_t;

endpackage

`default_nettype wire

// ----- src/bole_ram.sv -----
// ---------------------------------------------------------------------------
// bole_ram
// generic ram, one write port and two registered read ports
// ---------------------------------------------------------------------------
`default_nettype none

module bole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output      logic [WIDTH-1:0]         rdata_a_o,
  output      logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ----- src/bounded_ordered_list_engine_top.sv -----
// ---------------------------------------------------------------------------
// bounded_ordered_list_engine_top
// ordered list of up to DEPTH signed values with positional insert and
// delete, delete by key, reverse and dump
// ---------------------------------------------------------------------------
// One request at a time is taken; in_ready_o is low until its last result
// is in the output register. Every step walks the entry RAM (one write, two
// registered reads per cycle) under a small sequencer. Insert moves the
// entries from the position on up by one and writes the new value, delete
// moves the entries above the position down by one, delete by key scans
// from the head and deletes the first match, reverse swaps pairs from both
// ends inward, dump emits up to RESULT_CAP items as the output takes them.
// The next request is taken while the last result still waits at the output.
`default_nettype none
`include "bounded_ordered_list_engine_top_assert.svh"

module bounded_ordered_list_engine_top
  import bole_pkg::*;
#(
  parameter int DEPTH = BOLE_DEPTH
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_ready_o,
  input  wire bole_req_t in_item_i,
  output      logic      out_valid_o,
  input  wire logic      out_ready_i,
  output      bole_rsp_t out_item_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > 5) ? CW : 5) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_SH, S_INS_PUT, S_DEL_SH, S_DEL_END,
    S_KEY, S_REV_A, S_REV_B, S_DUMP, S_FIN
  } state_e;

  state_e                  state_q, state_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [AW-1:0]           idx_q, idx_d;
  logic [AW-1:0]           hi_q, hi_d;
  logic [AW-1:0]           lim_q, lim_d;
  logic [AW-1:0]           tgt_q, tgt_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic signed [VAL_W-1:0] key_q, key_d;
  logic signed [VAL_W-1:0] tmp_q, tmp_d;
  logic [2:0]              status_q, status_d;
  bole_rsp_t               out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic signed [VAL_W-1:0] ram_wdata;
  logic [AW-1:0]           raddr_a, raddr_b;
  logic signed [VAL_W-1:0] rdata_a, rdata_b;

  logic [XW-1:0] cnt_x, pos_x, dump_n;
  logic [AW-1:0] lim_c, idx_p1, idx_p2, idx_m1, hi_m1;
  logic          out_free;

  assign cnt_x  = XW'(cnt_q);
  assign pos_x  = XW'(in_item_i.position);
  assign lim_c  = AW'(cnt_x - XW'(1));
  assign dump_n = (cnt_x > XW'(RESULT_CAP)) ? XW'(RESULT_CAP) : cnt_x;
  assign idx_p1 = idx_q + 1'b1;
  assign idx_p2 = idx_p1 + 1'b1;
  assign idx_m1 = idx_q - 1'b1;
  assign hi_m1  = hi_q - 1'b1;
  assign out_free = !out_valid_q || out_ready_i;

  bole_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    hi_d        = hi_q;
    lim_d       = lim_q;
    tgt_d       = tgt_q;
    val_d       = val_q;
    key_d       = key_q;
    tmp_d       = tmp_q;
    status_d    = status_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = rdata_a;
    raddr_a     = idx_q;
    raddr_b     = hi_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d    = in_item_i.new_value;
          key_d    = in_item_i.search_key;
          tgt_d    = AW'(pos_x - XW'(1));
          lim_d    = lim_c;
          idx_d    = '0;
          status_d = ST_OK;
          state_d  = S_FIN;
          unique case (in_item_i.req_type)
            REQ_INSERT: begin
              if (cnt_x == XW'(DEPTH)) begin
                status_d = ST_FULL;
              end else if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
                status_d = ST_BADPOS;
              end else if (pos_x - XW'(1) == cnt_x) begin
                state_d = S_INS_PUT;
              end else begin
                raddr_a = lim_c;
                idx_d   = lim_c;
                state_d = S_INS_SH;
              end
            end
            REQ_DEL_POS: begin
              if (cnt_x == '0) begin
                status_d = ST_EMPTY;
              end else if (pos_x == '0 || pos_x > cnt_x) begin
                status_d = ST_BADPOS;
              end else if (pos_x == cnt_x) begin
                state_d = S_DEL_END;
              end else begin
                raddr_a = AW'(pos_x);
                idx_d   = AW'(pos_x - XW'(1));
                state_d = S_DEL_SH;
              end
            end
            REQ_DEL_KEY: begin
              if (cnt_x == '0) begin
                status_d = ST_EMPTY;
              end else begin
                raddr_a = '0;
                state_d = S_KEY;
              end
            end
            REQ_REVERSE: begin
              if (cnt_x == '0) begin
                status_d = ST_EMPTY;
              end else if (cnt_x != XW'(1)) begin
                raddr_a = '0;
                raddr_b = lim_c;
                hi_d    = lim_c;
                state_d = S_REV_A;
              end
            end
            REQ_DUMP: begin
              if (cnt_x == '0) begin
                status_d = ST_EMPTY;
              end else begin
                raddr_a = '0;
                lim_d   = AW'(dump_n - XW'(1));
                state_d = S_DUMP;
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end
      S_INS_SH: begin
        ram_we    = 1'b1;
        ram_waddr = idx_p1;
        ram_wdata = rdata_a;
        if (idx_q == tgt_q) begin
          state_d = S_INS_PUT;
        end else begin
          raddr_a = idx_m1;
          idx_d   = idx_m1;
        end
      end
      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = tgt_q;
        ram_wdata = val_q;
        cnt_d     = cnt_q + 1'b1;
        state_d   = S_FIN;
      end
      S_DEL_SH: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = rdata_a;
        if (idx_p1 == lim_q) begin
          state_d = S_DEL_END;
        end else begin
          raddr_a = idx_p2;
          idx_d   = idx_p1;
        end
      end
      S_DEL_END: begin
        cnt_d   = cnt_q - 1'b1;
        state_d = S_FIN;
      end
      S_KEY: begin
        if (rdata_a == key_q) begin
          if (idx_q == lim_q) begin
            state_d = S_DEL_END;
          end else begin
            raddr_a = idx_p1;
            state_d = S_DEL_SH;
          end
        end else if (idx_q == lim_q) begin
          status_d = ST_NOKEY;
          state_d  = S_FIN;
        end else begin
          raddr_a = idx_p1;
          idx_d   = idx_p1;
        end
      end
      S_REV_A: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = rdata_b;
        tmp_d     = rdata_a;
        state_d   = S_REV_B;
      end
      S_REV_B: begin
        ram_we    = 1'b1;
        ram_waddr = hi_q;
        ram_wdata = tmp_q;
        idx_d     = idx_p1;
        hi_d      = hi_m1;
        if (idx_p1 < hi_m1) begin
          raddr_a = idx_p1;
          raddr_b = hi_m1;
          state_d = S_REV_A;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_d.status        = ST_OK;
          out_d.out_value     = rdata_a;
          out_d.element_count = 5'(cnt_q);
          out_d.last_flag     = (idx_q == lim_q);
          out_valid_d         = 1'b1;
          if (idx_q == lim_q) begin
            state_d = S_IDLE;
          end else begin
            raddr_a = idx_p1;
            idx_d   = idx_p1;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_d.status        = status_q;
          out_d.out_value     = '0;
          out_d.element_count = 5'(cnt_q);
          out_d.last_flag     = 1'b1;
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      hi_q        <= '0;
      lim_q       <= '0;
      tgt_q       <= '0;
      val_q       <= '0;
      key_q       <= '0;
      tmp_q       <= '0;
      status_q    <= ST_OK;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      hi_q        <= hi_d;
      lim_q       <= lim_d;
      tgt_q       <= tgt_d;
      val_q       <= val_d;
      key_q       <= key_d;
      tmp_q       <= tmp_d;
      status_q    <= status_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `BOLE_ASSERT(a_cnt_bounded, clk_i, rst_ni, cnt_q <= CW'(DEPTH), "count above depth")
  `BOLE_ASSERT(a_cnt_step, clk_i, rst_ni, !$stable(cnt_q) |-> (cnt_q == $past(cnt_q) + 1'b1 || cnt_q == $past(cnt_q) - 1'b1), "count moved by more than one")
  `BOLE_ASSERT(a_cnt_hold_on_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> $stable(cnt_q), "count changed at accept")
  `BOLE_ASSERT_NEVER(a_err_single, clk_i, rst_ni, out_valid_o && out_item_o.status != ST_OK && !out_item_o.last_flag, "error item without last flag")
  `BOLE_ASSERT_NEVER(a_dump_nonempty, clk_i, rst_ni, state_q == S_DUMP && cnt_q == '0, "dump on empty list")

endmodule

`default_nettype wire

// ----- dv/bounded_ordered_list_engine_top_tb.sv -----
// ---------------------------------------------------------------------------
// bounded_ordered_list_engine_top_tb
// walks a directed table of list requests (empty list, bad positions, signed
// extremes, unknown codes), then random bursts that fill, drain and shuffle
// the list, with random idling on both sides and one long output stall.
// each result is checked by field against table or a behavioral predictor.
// ---------------------------------------------------------------------------
`default_nettype none

module bounded_ordered_list_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bole_pkg::*;

  localparam int NUM_RANDOM = 156;
  localparam int NUM_DIRECTED = 24;
  localparam int HOLD_CYCLES = 80;

  typedef enum int {GROW_BURST, SHRINK_BURST, ANY_BURST} burst_kind_e;

  typedef struct packed {
    bole_req_t req;
    logic      typed;
    bole_rsp_t rsp;
  } dir_row_t;

  function automatic bole_req_t mk_req(logic [2:0] t, logic [31:0] v, logic [4:0] p,
                                       logic [31:0] k);
    mk_req = '{t, v, p, k};
  endfunction

  function automatic bole_rsp_t mk_rsp(logic [2:0] st, logic [4:0] cnt);
    mk_rsp = '{st, 32'sd0, cnt, 1'b1};
  endfunction

  localparam dir_row_t DIR_TAB [NUM_DIRECTED] = '{
    '{mk_req(REQ_DUMP,    32'h0,         5'd0,  32'h0),        1'b1, mk_rsp(ST_EMPTY, 5'd0)},
    '{mk_req(REQ_REVERSE, 32'h0,         5'd0,  32'h0),        1'b1, mk_rsp(ST_EMPTY, 5'd0)},
    '{mk_req(REQ_DEL_POS, 32'h0,         5'd1,  32'h0),        1'b1, mk_rsp(ST_EMPTY, 5'd0)},
    '{mk_req(REQ_DEL_KEY, 32'h0,         5'd0,  32'h0),        1'b1, mk_rsp(ST_EMPTY, 5'd0)},
    '{mk_req(REQ_INSERT,  32'h5,         5'd0,  32'h0),        1'b1, mk_rsp(ST_BADPOS, 5'd0)},
    '{mk_req(REQ_INSERT,  32'h5,         5'd2,  32'h0),        1'b1, mk_rsp(ST_BADPOS, 5'd0)},
    '{mk_req(REQ_INSERT,  32'h7fff_ffff, 5'd1,  32'h0),        1'b1, mk_rsp(ST_OK, 5'd1)},
    '{mk_req(REQ_INSERT,  32'h8000_0000, 5'd1,  32'h0),        1'b0, '0},
    '{mk_req(REQ_INSERT,  32'hffff_ffff, 5'd3,  32'h0),        1'b0, '0},
    '{mk_req(REQ_INSERT,  32'h0,         5'd2,  32'h0),        1'b0, '0},
    '{mk_req(REQ_INSERT,  32'h1,         5'd6,  32'h0),        1'b1, mk_rsp(ST_BADPOS, 5'd4)},
    '{mk_req(3'd5,        32'h1234_5678, 5'd1,  32'h0),        1'b1, mk_rsp(ST_OK, 5'd4)},
    '{mk_req(REQ_DUMP,    32'h0,         5'd0,  32'h0),        1'b0, '0},
    '{mk_req(REQ_REVERSE, 32'h0,         5'd0,  32'h0),        1'b0, '0},
    '{mk_req(REQ_DUMP,    32'h0,         5'd0,  32'h0),        1'b0, '0},
    '{mk_req(REQ_DEL_KEY, 32'h0,         5'd0,  32'd12345),    1'b1, mk_rsp(ST_NOKEY, 5'd4)},
    '{mk_req(REQ_DEL_KEY, 32'h0,         5'd0,  32'h8000_0000), 1'b0, '0},
    '{mk_req(REQ_DEL_POS, 32'h0,         5'd0,  32'h0),        1'b1, mk_rsp(ST_BADPOS, 5'd3)},
    '{mk_req(REQ_DEL_POS, 32'h0,         5'd4,  32'h0),        1'b1, mk_rsp(ST_BADPOS, 5'd3)},
    '{mk_req(REQ_DEL_POS, 32'h0,         5'd31, 32'h0),        1'b1, mk_rsp(ST_BADPOS, 5'd3)},
    '{mk_req(REQ_DEL_POS, 32'h0,         5'd3,  32'h0),        1'b0, '0},
    '{mk_req(3'd7,        32'hffff_ffff, 5'd31, 32'hffff_ffff), 1'b0, '0},
    '{mk_req(REQ_INSERT,  32'h9,         5'd31, 32'h0),        1'b1, mk_rsp(ST_BADPOS, 5'd2)},
    '{mk_req(REQ_DUMP,    32'h0,         5'd0,  32'h0),        1'b0, '0}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  bole_req_t in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  bole_rsp_t out_item;

  logic signed [VAL_W-1:0] list_mem [BOLE_DEPTH];
  int        list_len = 0;
  bole_rsp_t rsp_due_q [$];
  int        n_accepted = 0;
  int        n_results = 0;
  int        n_errors = 0;
  int        req_seen [8];
  int        status_seen [8];

  wire quiet_run = (n_accepted >= 110) && (n_accepted < 150);

  bounded_ordered_list_engine_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results still due", rsp_due_q.size());
    $display("FAIL");
    $finish;
  end

  function automatic void list_drop(int idx);
    for (int i = idx; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
    list_len--;
  endfunction

  // updates the list and, unless state_only, queues a request's results
  task automatic list_apply(input bole_req_t r, input bit state_only);
    logic [2:0] st;
    int pos;
    int lo;
    int hi;
    int n;
    logic signed [VAL_W-1:0] t;
    st = ST_OK;
    pos = int'(r.position);
    case (r.req_type)
      REQ_INSERT: begin
        if (list_len >= BOLE_DEPTH) st = ST_FULL;
        else if (pos < 1 || pos > list_len + 1) st = ST_BADPOS;
        else begin
          for (int i = list_len; i >= pos; i--) list_mem[i] = list_mem[i - 1];
          list_mem[pos - 1] = r.new_value;
          list_len++;
        end
      end
      REQ_DEL_POS: begin
        if (list_len == 0) st = ST_EMPTY;
        else if (pos < 1 || pos > list_len) st = ST_BADPOS;
        else list_drop(pos - 1);
      end
      REQ_DEL_KEY: begin
        if (list_len == 0) st = ST_EMPTY;
        else begin
          st = ST_NOKEY;
          for (int i = 0; i < list_len; i++) begin
            if (list_mem[i] == r.search_key) begin
              list_drop(i);
              st = ST_OK;
              break;
            end
          end
        end
      end
      REQ_REVERSE: begin
        if (list_len == 0) st = ST_EMPTY;
        else begin
          lo = 0;
          hi = list_len - 1;
          while (lo < hi) begin
            t = list_mem[lo];
            list_mem[lo] = list_mem[hi];
            list_mem[hi] = t;
            lo++;
            hi--;
          end
        end
      end
      REQ_DUMP: begin
        if (list_len == 0) st = ST_EMPTY;
        else begin
          n = (list_len > RESULT_CAP) ? RESULT_CAP : list_len;
          if (!state_only)
            for (int i = 0; i < n; i++)
              rsp_due_q.push_back('{ST_OK, list_mem[i], 5'(list_len), i == n - 1});
          return;
        end
      end
      default: ;
    endcase
    if (!state_only) rsp_due_q.push_back('{st, 32'sd0, 5'(list_len), 1'b1});
  endtask

  task automatic send_req(input bole_req_t r, input bit typed, input bole_rsp_t want);
    while (!quiet_run && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    list_apply(r, typed);
    if (typed) rsp_due_q.push_back(want);
    req_seen[r.req_type]++;
    n_accepted++;
  endtask

  function automatic bole_req_t next_req(burst_kind_e kind);
    bole_req_t r;
    int roll;
    roll = $urandom_range(99);
    r.new_value  = $urandom;
    r.search_key = $urandom;
    r.position   = 5'($urandom_range(31));
    case (kind)
      GROW_BURST:
        r.req_type = (roll < 75) ? REQ_INSERT : (roll < 85) ? REQ_DUMP : 3'($urandom_range(7));
      SHRINK_BURST:
        if (roll < 35) r.req_type = REQ_DEL_POS;
        else if (roll < 65) r.req_type = REQ_DEL_KEY;
        else if (roll < 75) r.req_type = REQ_REVERSE;
        else if (roll < 85) r.req_type = REQ_DUMP;
        else r.req_type = 3'($urandom_range(7));
      default: r.req_type = 3'($urandom_range(7));
    endcase
    if ($urandom_range(99) < 85) begin
      if (r.req_type == REQ_INSERT) r.position = 5'($urandom_range(list_len + 1, 1));
      else if (list_len > 0) r.position = 5'($urandom_range(list_len, 1));
    end
    roll = $urandom_range(99);
    if (roll < 20) r.new_value = $urandom_range(3);
    else if (roll < 30)
      case ($urandom_range(3))
        0: r.new_value = 32'sh8000_0000;
        1: r.new_value = 32'sh7fff_ffff;
        2: r.new_value = -32'sd1;
        default: r.new_value = 32'sd0;
      endcase
    if (list_len > 0 && $urandom_range(99) < 70)
      r.search_key = list_mem[$urandom_range(list_len - 1)];
    return r;
  endfunction

  // receiver: random stalls, one long hold-off, a stretch without stalls
  initial begin : drain
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held && n_accepted >= 40) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet_run || ($urandom_range(99) >= 11);
      end
      @(posedge clk);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    bole_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      status_seen[out_item.status]++;
      if (rsp_due_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, out_item);
        n_errors++;
      end else begin
        want = rsp_due_q.pop_front();
        check_field("status", 32'(want.status), 32'(out_item.status));
        check_field("out_value", want.out_value, out_item.out_value);
        check_field("element_count", 32'(want.element_count), 32'(out_item.element_count));
        check_field("last_flag", 32'(want.last_flag), 32'(out_item.last_flag));
      end
    end
  end

  initial begin : stimulus
    burst_kind_e kind;
    int burst_len;
    int sent_random;
    for (int i = 0; i < 8; i++) begin
      req_seen[i] = 0;
      status_seen[i] = 0;
    end
    for (int i = 0; i < BOLE_DEPTH; i++) list_mem[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < NUM_DIRECTED; k++)
      send_req(DIR_TAB[k].req, DIR_TAB[k].typed, DIR_TAB[k].rsp);

    sent_random = 0;
    kind = GROW_BURST;
    burst_len = 30;
    while (sent_random < NUM_RANDOM) begin
      for (int k = 0; k < burst_len && sent_random < NUM_RANDOM; k++) begin
        send_req(next_req(kind), 1'b0, '0);
        sent_random++;
      end
      kind = (list_len < 4) ? GROW_BURST : burst_kind_e'($urandom_range(2));
      burst_len = $urandom_range(24, 10);
    end
    in_valid <= 1'b0;

    while (rsp_due_q.size() != 0) @(posedge clk);
    repeat (2 * BOLE_DEPTH + 8) @(posedge clk);

    $display("run covered %0d requests (%0d inserts, %0d deletes, %0d dumps, %0d reverses)",
             n_accepted, req_seen[REQ_INSERT], req_seen[REQ_DEL_POS] + req_seen[REQ_DEL_KEY],
             req_seen[REQ_DUMP], req_seen[REQ_REVERSE]);
    $display("%0d results: ok %0d, full %0d, bad position %0d, no key %0d, empty %0d",
             n_results, status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BADPOS],
             status_seen[ST_NOKEY], status_seen[ST_EMPTY]);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+src
src/bole_pkg.sv
src/bole_ram.sv
src/bounded_ordered_list_engine_top.sv
dv/bounded_ordered_list_engine_top_tb.sv
